FILE: hw/rtl/erv_pkg.sv
// Shared types, constants and the coefficient build sequence for the vertex rotator.
package erv_pkg;

	localparam int TURN_BITS    = 24;
	localparam int RES_BITS     = 22;
	localparam int CORDIC_STEPS = 16;
	localparam int COEF_W       = 17;
	localparam int XY_W         = 34;
	localparam int Z_W          = 25;
	localparam int CFG_IDX_W    = 2;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic [8:0][COEF_W-1:0]   coef_arr_t;

	localparam coef_t ONE_Q15 = 17'sd32768;
	localparam coef_t NEG_ONE = -17'sd32768;
	localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sd652032874;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_YAW   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROLL  = 2'd2;

	// product operands
	localparam logic [3:0] OP_CY  = 4'd0;
	localparam logic [3:0] OP_SY  = 4'd1;
	localparam logic [3:0] OP_CP  = 4'd2;
	localparam logic [3:0] OP_SP  = 4'd3;
	localparam logic [3:0] OP_CR  = 4'd4;
	localparam logic [3:0] OP_SR  = 4'd5;
	localparam logic [3:0] OP_T0  = 4'd6;
	localparam logic [3:0] OP_T1  = 4'd7;
	localparam logic [3:0] OP_NEG = 4'd8;

	// destinations: 0..8 are the coefficients
	localparam logic [3:0] DST_T0 = 4'd9;
	localparam logic [3:0] DST_T1 = 4'd10;
	localparam logic [3:0] DST_M  = 4'd11;

	// combine modes
	localparam logic [1:0] MD_PUT = 2'd0;
	localparam logic [1:0] MD_ADD = 2'd1;
	localparam logic [1:0] MD_SUB = 2'd2;

	localparam logic [3:0] MUL_LAST = 4'd14;

	typedef struct packed {
		logic [3:0] op_a;
		logic [3:0] op_b;
		logic [3:0] dst;
		logic [1:0] mode;
	} mstep_t;

	function automatic mstep_t mul_step(input logic [3:0] n);
		mstep_t r;
		case (n)
			4'd0:    r = '{OP_CY, OP_SP, DST_T0, MD_PUT};
			4'd1:    r = '{OP_SY, OP_SP, DST_T1, MD_PUT};
			4'd2:    r = '{OP_CY, OP_CP, 4'd0,   MD_PUT};
			4'd3:    r = '{OP_SY, OP_CR, DST_M,  MD_PUT};
			4'd4:    r = '{OP_T0, OP_SR, 4'd1,   MD_SUB};
			4'd5:    r = '{OP_SY, OP_SR, DST_M,  MD_PUT};
			4'd6:    r = '{OP_T0, OP_CR, 4'd2,   MD_ADD};
			4'd7:    r = '{OP_SY, OP_CP, 4'd3,   MD_PUT};
			4'd8:    r = '{OP_CY, OP_CR, DST_M,  MD_PUT};
			4'd9:    r = '{OP_T1, OP_SR, 4'd4,   MD_ADD};
			4'd10:   r = '{OP_CY, OP_SR, DST_M,  MD_PUT};
			4'd11:   r = '{OP_T1, OP_CR, 4'd5,   MD_SUB};
			4'd12:   r = '{OP_SP, OP_NEG, 4'd6,  MD_PUT};
			4'd13:   r = '{OP_CP, OP_SR, 4'd7,   MD_PUT};
			4'd14:   r = '{OP_CP, OP_CR, 4'd8,   MD_PUT};
			default: r = '{OP_CP, OP_CR, 4'd8,   MD_PUT};
		endcase
		return r;
	endfunction

	// atan(2^-i) in 2^-24 turn units
	function automatic logic signed [Z_W-1:0] atan_turn(input logic [3:0] i);
		logic signed [Z_W-1:0] r;
		case (i)
			4'd0:    r = 25'sd2097152;
			4'd1:    r = 25'sd1238021;
			4'd2:    r = 25'sd654136;
			4'd3:    r = 25'sd332050;
			4'd4:    r = 25'sd166669;
			4'd5:    r = 25'sd83416;
			4'd6:    r = 25'sd41718;
			4'd7:    r = 25'sd20860;
			4'd8:    r = 25'sd10430;
			4'd9:    r = 25'sd5215;
			4'd10:   r = 25'sd2608;
			4'd11:   r = 25'sd1304;
			4'd12:   r = 25'sd652;
			4'd13:   r = 25'sd326;
			4'd14:   r = 25'sd163;
			4'd15:   r = 25'sd81;
			default: r = 25'sd0;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/erv_coef.sv
// Coefficient builder: iterative CORDIC for three angles, then a sequenced Q1.15 product unit.
module erv_coef #(
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [erv_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ANGLE_WIDTH-1:0]                cfg_data,
	output logic                                  busy,
	output erv_pkg::coef_arr_t                    coefs
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_ITER = 2'd2;
	localparam logic [1:0] ST_MUL  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] sel_q;
	logic [3:0] cnt_q;
	logic [ANGLE_WIDTH-1:0] ang_q [3];
	logic signed [erv_pkg::XY_W-1:0] x_q, y_q;
	logic signed [erv_pkg::Z_W-1:0]  z_q;
	logic [1:0] quad_q;
	logic       zero_q;
	erv_pkg::coef_t cy_q, sy_q, cp_q, sp_q, cr_q, sr_q, t0_q, t1_q, m_q;
	erv_pkg::coef_t coef_q [9];

	// end-of-angle flag: raised in the cycle after the last CORDIC step
	logic fin_q, fin_now, res_dst_k;

	function automatic erv_pkg::coef_t clamp_one(input logic signed [19:0] v);
		if (v > 20'sd32768)
			return erv_pkg::ONE_Q15;
		if (v < -20'sd32768)
			return erv_pkg::NEG_ONE;
		return v[erv_pkg::COEF_W-1:0];
	endfunction

	function automatic erv_pkg::coef_t pick(input logic [3:0] op, input erv_pkg::coef_t cy,
			input erv_pkg::coef_t sy, input erv_pkg::coef_t cp, input erv_pkg::coef_t sp,
			input erv_pkg::coef_t cr, input erv_pkg::coef_t sr, input erv_pkg::coef_t t0,
			input erv_pkg::coef_t t1);
		erv_pkg::coef_t r;
		case (op)
			erv_pkg::OP_CY: r = cy;
			erv_pkg::OP_SY: r = sy;
			erv_pkg::OP_CP: r = cp;
			erv_pkg::OP_SP: r = sp;
			erv_pkg::OP_CR: r = cr;
			erv_pkg::OP_SR: r = sr;
			erv_pkg::OP_T0: r = t0;
			erv_pkg::OP_T1: r = t1;
			default:        r = erv_pkg::NEG_ONE;
		endcase
		return r;
	endfunction

	// angle to quadrant and residual
	logic [erv_pkg::TURN_BITS-1:0] turn;
	assign turn = erv_pkg::TURN_BITS'(ang_q[sel_q]) << (erv_pkg::TURN_BITS - ANGLE_WIDTH);

	// CORDIC rotation step
	logic signed [erv_pkg::XY_W-1:0] dx, dy;
	logic signed [erv_pkg::Z_W-1:0]  at;
	assign dx = y_q >>> cnt_q;
	assign dy = x_q >>> cnt_q;
	assign at = erv_pkg::atan_turn(cnt_q);

	// final rounding and quadrant mapping
	logic signed [erv_pkg::XY_W-1:0] xr, yr;
	erv_pkg::coef_t c_raw, s_raw, c_fin, s_fin;
	always_comb begin
		xr = x_q + erv_pkg::XY_W'(16384);
		yr = y_q + erv_pkg::XY_W'(16384);
		if (zero_q) begin
			c_raw = erv_pkg::ONE_Q15;
			s_raw = '0;
		end else begin
			c_raw = clamp_one(20'(xr >>> 15));
			s_raw = clamp_one(20'(yr >>> 15));
		end
		case (quad_q)
			2'd0: begin c_fin = c_raw;  s_fin = s_raw;  end
			2'd1: begin c_fin = -s_raw; s_fin = c_raw;  end
			2'd2: begin c_fin = -c_raw; s_fin = -s_raw; end
			default: begin c_fin = s_raw; s_fin = -c_raw; end
		endcase
	end

	// product unit: one rounded Q1.15 multiply per cycle, then combine
	erv_pkg::mstep_t ms;
	erv_pkg::coef_t  opa, opb, pq, res;
	logic signed [2*erv_pkg::COEF_W-1:0] prod;
	always_comb begin
		ms   = erv_pkg::mul_step(cnt_q);
		opa  = pick(ms.op_a, cy_q, sy_q, cp_q, sp_q, cr_q, sr_q, t0_q, t1_q);
		opb  = pick(ms.op_b, cy_q, sy_q, cp_q, sp_q, cr_q, sr_q, t0_q, t1_q);
		prod = opa * opb + (2*erv_pkg::COEF_W)'(16384);
		pq   = clamp_one(20'(prod >>> 15));
		case (ms.mode)
			erv_pkg::MD_ADD: res = clamp_one(20'(pq) + 20'(m_q));
			erv_pkg::MD_SUB: res = clamp_one(20'(pq) - 20'(m_q));
			default:         res = pq;
		endcase
	end

	assign fin_now   = fin_q;
	assign res_dst_k = !fin_q && ms.dst < erv_pkg::DST_T0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= '0;
			cnt_q   <= '0;
			for (int i = 0; i < 3; i++)
				ang_q[i] <= '0;
			for (int i = 0; i < 9; i++)
				coef_q[i] <= (i % 4 == 0) ? erv_pkg::ONE_Q15 : '0;
		end else if (fin_now) begin
			// end-of-angle cycle: next angle, or the product pass after roll
			if (sel_q == erv_pkg::REG_ROLL) begin
				state_q <= ST_MUL;
				cnt_q   <= '0;
			end else begin
				sel_q   <= sel_q + 2'd1;
				state_q <= ST_LOAD;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_write && (cfg_index == erv_pkg::REG_YAW ||
							cfg_index == erv_pkg::REG_PITCH || cfg_index == erv_pkg::REG_ROLL)) begin
						ang_q[cfg_index] <= cfg_data;
						sel_q   <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_ITER;
				end
				ST_ITER: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(erv_pkg::CORDIC_STEPS - 1))
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == erv_pkg::MUL_LAST)
						state_q <= ST_IDLE;
					if (res_dst_k)
						coef_q[ms.dst] <= res;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fin_q <= 1'b0;
		else
			fin_q <= (state_q == ST_ITER) && (cnt_q == 4'(erv_pkg::CORDIC_STEPS - 1));
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			x_q    <= erv_pkg::CORDIC_X0;
			y_q    <= '0;
			z_q    <= erv_pkg::Z_W'(turn[erv_pkg::RES_BITS-1:0]);
			quad_q <= turn[erv_pkg::TURN_BITS-1 -: 2];
			zero_q <= turn[erv_pkg::RES_BITS-1:0] == '0;
		end else if (state_q == ST_ITER) begin
			if (!z_q[erv_pkg::Z_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
		if (fin_q) begin
			case (sel_q)
				erv_pkg::REG_YAW:   begin cy_q <= c_fin; sy_q <= s_fin; end
				erv_pkg::REG_PITCH: begin cp_q <= c_fin; sp_q <= s_fin; end
				default: begin cr_q <= c_fin; sr_q <= s_fin; end
			endcase
		end else if (state_q == ST_MUL) begin
			case (ms.dst)
				erv_pkg::DST_T0: t0_q <= res;
				erv_pkg::DST_T1: t1_q <= res;
				erv_pkg::DST_M:  m_q  <= res;
				default: ;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE) || fin_q;

	always_comb begin
		for (int i = 0; i < 9; i++)
			coefs[i] = coef_q[i];
	end

endmodule

FILE: hw/rtl/erv_xform.sv
// Four-stage matrix-vector datapath: split products, product merge, row sums, round and saturate.
module erv_xform #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_take,
	input  logic                          out_stall,
	input  logic signed [COORD_WIDTH-1:0] vx,
	input  logic signed [COORD_WIDTH-1:0] vy,
	input  logic signed [COORD_WIDTH-1:0] vz,
	input  erv_pkg::coef_arr_t            coefs,
	output logic                          front_open,
	output logic                          out_valid,
	output logic signed [COORD_WIDTH-1:0] rx,
	output logic signed [COORD_WIDTH-1:0] ry,
	output logic signed [COORD_WIDTH-1:0] rz
);

	localparam int CW  = COORD_WIDTH;
	localparam int LW  = CW / 2;
	localparam int HW  = CW - LW;
	localparam int KW  = erv_pkg::COEF_W;
	localparam int PW  = CW + KW;
	localparam int SW  = CW + KW + 2;
	localparam int TW  = SW - 15;
	localparam logic signed [TW-1:0] MAXV = TW'({1'b0, {(CW-1){1'b1}}});
	localparam logic signed [TW-1:0] MINV = -MAXV - TW'(1);

	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v4_s4 || !out_stall;
	assign en3 = !v3_s3 || en4;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;
	assign front_open = en1;

	logic signed [CW-1:0] coord [3];
	assign coord[0] = vx;
	assign coord[1] = vy;
	assign coord[2] = vz;

	logic signed [LW+KW:0]   plo_s1 [9];
	logic signed [HW+KW-1:0] phi_s1 [9];
	logic signed [PW-1:0]    prod_s2 [9];
	logic signed [SW-1:0]    sum_s3 [3];
	logic signed [CW-1:0]    out_s4 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= in_take;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
		end
	end

	for (genvar j = 0; j < 9; j++) begin : g_prod
		always_ff @(posedge clk) begin
			if (en1 && in_take) begin
				plo_s1[j] <= $signed({1'b0, coord[j%3][LW-1:0]}) * $signed(coefs[j]);
				phi_s1[j] <= $signed(coord[j%3][CW-1:LW]) * $signed(coefs[j]);
			end
			if (en2 && v1_s1)
				prod_s2[j] <= (PW'(phi_s1[j]) <<< LW) + PW'(plo_s1[j]);
		end
	end

	for (genvar r = 0; r < 3; r++) begin : g_row
		logic signed [TW-1:0] sh;
		assign sh = sum_s3[r][SW-1:15];
		always_ff @(posedge clk) begin
			if (en3 && v2_s2)
				sum_s3[r] <= SW'(prod_s2[3*r]) + SW'(prod_s2[3*r+1]) + SW'(prod_s2[3*r+2])
					+ SW'(16384);
			if (en4 && v3_s3) begin
				if (sh > MAXV)
					out_s4[r] <= MAXV[CW-1:0];
				else if (sh < MINV)
					out_s4[r] <= MINV[CW-1:0];
				else
					out_s4[r] <= sh[CW-1:0];
			end
		end
	end

	assign out_valid = v4_s4;
	assign rx = out_s4[0];
	assign ry = out_s4[1];
	assign rz = out_s4[2];

endmodule

FILE: hw/rtl/euler_rotate_vertex.sv
// Top level of the yaw-pitch-roll vertex rotator.
//
// Rotates signed Q16.16 vertices by the Z-Y-X matrix built from three binary angles
// (a full turn is 2^ANGLE_WIDTH) and emits the rotated vertex, rounded and saturated.
// Input channel:  in_valid / in_stall with vertex_x, vertex_y, vertex_z.
// Output channel: out_valid / out_stall with rotated_x, rotated_y, rotated_z.
// A transfer happens at a rising edge where valid is high and stall is low.
// Config: cfg_write, cfg_index (0 yaw, 1 pitch, 2 roll), cfg_data; index 3 is ignored.
// Throughput: one vertex per cycle unless a rebuild or a full, stalled pipeline holds input off;
// the four pipeline stages (split multiplies, product merge, row sums, round/saturate)
// each hold their item only while the next stage is full and stalled.
// A config write rebuilds the nine coefficients: for each of the three angles a load
// step, 16 CORDIC iterations and a finishing step, then the sequenced steps of the
// shared 17x17 product unit. in_stall is held high during the rebuild.
// Reset clears all angles to zero (identity matrix) and empties the pipeline.
// When out_stall is held, the output stays put and stages fill behind it until
// in_stall rises; nothing is dropped or repeated.
module euler_rotate_vertex #(
	parameter int COORD_WIDTH = 32,
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [erv_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ANGLE_WIDTH-1:0]                cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [COORD_WIDTH-1:0]         vertex_x,
	input  logic signed [COORD_WIDTH-1:0]         vertex_y,
	input  logic signed [COORD_WIDTH-1:0]         vertex_z,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [COORD_WIDTH-1:0]         rotated_x,
	output logic signed [COORD_WIDTH-1:0]         rotated_y,
	output logic signed [COORD_WIDTH-1:0]         rotated_z
);

	logic               busy;
	logic               front_open;
	erv_pkg::coef_arr_t coefs;

	// no vertex enters while coefficients are being rebuilt
	assign in_stall = busy || !front_open;

	erv_coef #(
		.ANGLE_WIDTH(ANGLE_WIDTH)
	) u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.coefs     (coefs)
	);

	erv_xform #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_xform (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_take    (in_valid && !in_stall),
		.out_stall  (out_stall),
		.vx         (vertex_x),
		.vy         (vertex_y),
		.vz         (vertex_z),
		.coefs      (coefs),
		.front_open (front_open),
		.out_valid  (out_valid),
		.rx         (rotated_x),
		.ry         (rotated_y),
		.rz         (rotated_z)
	);

endmodule

FILE: hw/rtl/erv_checker.sv
// Port-level checker for the vertex rotator and its bind.
module erv_checker #(
	parameter int COORD_WIDTH = 32
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_write,
	input logic [erv_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [COORD_WIDTH-1:0]        rotated_x,
	input logic [COORD_WIDTH-1:0]        rotated_y,
	input logic [COORD_WIDTH-1:0]        rotated_z
);

	logic quiet;
	assign quiet = !(in_valid && !in_stall) && !out_stall;

	// a known register write starts a rebuild that holds off input
	a_rebuild_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write && (cfg_index == erv_pkg::REG_YAW || cfg_index == erv_pkg::REG_PITCH ||
			cfg_index == erv_pkg::REG_ROLL) |=> in_stall)
		else $error("input not held during coefficient rebuild");

	// as many stall-free cycles with no new vertex as there are pipeline stages leave the pipeline empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		quiet ##1 quiet ##1 quiet ##1 quiet |=> !out_valid)
		else $error("result appeared without a matching input");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rotated_x) && $stable(rotated_y)
			&& $stable(rotated_z))
		else $error("stalled result changed");

endmodule

bind euler_rotate_vertex erv_checker #(
	.COORD_WIDTH(COORD_WIDTH)
) u_erv_checker (.*);
